@@ rtl/cbt_pkg.sv @@
// cbt_pkg: widths, codes, reset values and shared types of the block allocation table.
// No dependencies; compiled first.
package cbt_pkg;

  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 8;
  localparam int SIZE_W   = 24;
  localparam int USED_W   = 16;
  localparam int LEN_W    = 9;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam logic [USED_W-1:0] BLOCK_SIZE_RST   = 16'd4096;
  localparam logic [LEN_W-1:0]  TABLE_LENGTH_RST = 9'd256;

  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 1'd1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [USED_W-1:0]   used;
    logic [USED_W-1:0]   fragmented;
    logic                in_use;
    logic [LEN_W-1:0]    blocks_written;
  } result_t;

endpackage

@@ rtl/cbt_in_if.sv @@
// cbt_in_if / cbt_out_if: valid/ready channels for commands and results.
// Depends on cbt_pkg.
interface cbt_in_if;
  import cbt_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [INDEX_W-1:0] index;
  logic [SIZE_W-1:0]  size_used;

  modport source (output valid, cmd, index, size_used, input ready);
  modport sink   (input valid, cmd, index, size_used, output ready);
endinterface

interface cbt_out_if;
  import cbt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [USED_W-1:0]   used;
  logic [USED_W-1:0]   fragmented;
  logic                in_use;
  logic [LEN_W-1:0]    blocks_written;

  modport source (output valid, status, used, fragmented, in_use, blocks_written,
                  input ready);
  modport sink   (input valid, status, used, fragmented, in_use, blocks_written,
                  output ready);
endinterface

@@ rtl/contiguous_block_table.sv @@
// contiguous_block_table: table of equal-size blocks with used amount and in-use mark.
// Depends on cbt_pkg, cbt_in_if/cbt_out_if and cbt_ram.
//
// Usage:
//   in_ch carries commands (update from index, clear table, read entry); out_ch
//   returns exactly one result beat per command. cfg_we/cfg_index/cfg_wdata set block
//   size (index 0), table length (index 1); only while idle, a user rule not enforced.
//   One command at a time; the table lives in a single RAM, one entry per cycle.
//   Steps from accept to result valid:
//     refused or undefined command, clear of a zero-length table: no table access
//     read: one registered RAM read
//     update: 1 to length blocks, one RAM write each
//     clear: one RAM write per entry, length entries
//   The next command is taken the cycle after a result loads.
//   After reset the RAM is swept to zero, all TABLE_DEPTH entries, with in_ch.ready
//   low; configuration writes are taken during the sweep.
//   A result waits in the output register while out_ch.ready is low; the next
//   command is still accepted and worked on, and its result waits until the
//   output register frees.
module contiguous_block_table #(
  parameter int TABLE_DEPTH = cbt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  cbt_in_if.sink                         in_ch,
  cbt_out_if.source                      out_ch
);
  import cbt_pkg::*;

  localparam int AW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DEPTH_CAP = (TABLE_DEPTH < 511) ? TABLE_DEPTH : 511;
  localparam int ENT_W     = USED_W + 1;

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_UPD, S_CLR, S_READ, S_RESP} state_t;

  state_t            state_r;
  logic [AW-1:0]     init_r;
  logic [USED_W-1:0] bs_r;
  logic [LEN_W-1:0]  len_r;
  logic [SIZE_W-1:0] rem_r;
  logic [LEN_W-1:0]  walk_r;
  logic [LEN_W-1:0]  cnt_r;
  result_t           res_r;
  logic              out_valid_r;
  result_t           out_r;

  logic [USED_W-1:0] bs_eff;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  walk_inc;
  logic              more;
  logic [USED_W-1:0] amt;
  logic [SIZE_W-1:0] rem_nxt;
  logic              out_free;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;
  logic              rd_iu;
  logic [USED_W-1:0] rd_used;
  logic              in_acc;
  logic              idx_bad;

  assign bs_eff   = (bs_r == '0) ? USED_W'(1) : bs_r;
  assign len_eff  = (len_r > LEN_W'(DEPTH_CAP)) ? LEN_W'(DEPTH_CAP) : len_r;
  assign walk_inc = walk_r + LEN_W'(1);
  // while more than one block_size is left a block takes a full block_size; else it takes what is left
  assign more     = rem_r > {{(SIZE_W-USED_W){1'b0}}, bs_eff};
  assign amt      = more ? bs_eff : rem_r[USED_W-1:0];
  assign rem_nxt  = rem_r - {{(SIZE_W-USED_W){1'b0}}, amt};
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign idx_bad  = {1'b0, in_ch.index} >= len_eff;
  assign rd_iu    = ram_rdata[ENT_W-1];
  assign rd_used  = ram_rdata[USED_W-1:0];

  always_comb begin
    ram_we    = (state_r == S_INIT) || (state_r == S_UPD) || (state_r == S_CLR);
    ram_waddr = (state_r == S_INIT) ? init_r : AW'(walk_r);
    ram_wdata = (state_r == S_UPD) ? {amt != '0, amt} : '0;
    ram_raddr = AW'(in_ch.index);
  end

  cbt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r  <= BLOCK_SIZE_RST;
      len_r <= TABLE_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_SIZE:   bs_r  <= cfg_wdata;
        CFG_TABLE_LENGTH: len_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      rem_r       <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          init_r <= init_r + AW'(1);
          if (init_r == AW'(TABLE_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            cnt_r <= '0;
            priority if (in_ch.cmd == CMD_CLEAR) begin
              res_r  <= '0;
              walk_r <= '0;
              if (len_eff == '0) begin
                state_r <= S_RESP;
              end else begin
                state_r <= S_CLR;
              end
            end else if (in_ch.cmd == CMD_NONE) begin
              res_r   <= '0;
              state_r <= S_RESP;
            end else if (idx_bad) begin
              res_r   <= '{status: ST_RANGE, default: '0};
              state_r <= S_RESP;
            end else if (in_ch.cmd == CMD_READ) begin
              res_r   <= '0;
              state_r <= S_READ;
            end else begin
              res_r   <= '0;
              walk_r  <= {1'b0, in_ch.index};
              rem_r   <= in_ch.size_used;
              state_r <= S_UPD;
            end
          end
        end
        S_UPD: begin
          rem_r  <= rem_nxt;
          walk_r <= walk_inc;
          cnt_r  <= cnt_r + LEN_W'(1);
          if (!more || walk_inc == len_eff) begin
            res_r.status         <= more ? ST_TRUNC : ST_OK;
            res_r.used           <= amt;
            res_r.in_use         <= amt != '0;
            res_r.fragmented     <= (amt != '0) ? bs_eff - amt : '0;
            res_r.blocks_written <= cnt_r + LEN_W'(1);
            state_r              <= S_RESP;
          end
        end
        S_CLR: begin
          walk_r <= walk_inc;
          if (walk_inc == len_eff) begin
            res_r.blocks_written <= len_eff;
            state_r              <= S_RESP;
          end
        end
        S_READ: begin
          res_r.used       <= rd_used;
          res_r.in_use     <= rd_iu;
          res_r.fragmented <= (rd_iu && bs_eff > rd_used) ? bs_eff - rd_used : '0;
          state_r          <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.used           = out_r.used;
  assign out_ch.fragmented     = out_r.fragmented;
  assign out_ch.in_use         = out_r.in_use;
  assign out_ch.blocks_written = out_r.blocks_written;

`ifndef NO_ASSERTIONS
  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_INIT || state_r == S_UPD || state_r == S_CLR))
    else $error("table write outside a write state");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD || state_r == S_CLR) |-> walk_r < len_eff)
    else $error("walk past table length");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_RANGE) |->
      (out_r.used == '0 && !out_r.in_use && out_r.blocks_written == '0))
    else $error("refused command reports data");

  a_inuse_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.in_use == (out_r.used != '0)))
    else $error("in-use mark disagrees with used amount");

  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && !out_free) |=> state_r == S_RESP)
    else $error("result dropped while output busy");
`endif

endmodule

@@ rtl/cbt_ram.sv @@
// cbt_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cbt_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
